### hw/rtl/ghd_pkg.sv
package ghd_pkg;

    localparam int CORDIC_ITERATIONS = 24;
    localparam int ITERS = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;

    // Degree input width after differencing or doubling.
    localparam int DW = 26;
    // Radian angle width, Q30 signed.
    localparam int AW = 36;
    // CORDIC x/y datapath width.
    localparam int CW = 34;

    localparam longint DEG2RAD_Q40 = 64'd19190098069;
    localparam longint KSPLIT = 64'd262144;
    localparam longint K_HI = DEG2RAD_Q40 / KSPLIT;
    localparam longint K_LO = DEG2RAD_Q40 % KSPLIT;

    localparam logic signed [AW-1:0] PI_Q30 = AW'(64'sd3373259426);
    localparam logic signed [AW-1:0] HALF_PI_Q30 = AW'(64'sd1686629713);
    localparam logic signed [AW-1:0] TWO_PI_Q30 = AW'(64'sd6746518852);
    localparam logic signed [CW-1:0] GAIN_Q30 = CW'(64'sd652032874);
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [12:0] RADIUS_RESET = 13'd3956;

    function automatic logic [31:0] atan_val(input int i);
        logic [31:0] v;
        case (i)
            0: v = 32'd843314856;
            1: v = 32'd497837829;
            2: v = 32'd263043836;
            3: v = 32'd133525158;
            4: v = 32'd67021686;
            5: v = 32'd33543515;
            6: v = 32'd16775850;
            7: v = 32'd8388437;
            8: v = 32'd4194282;
            9: v = 32'd2097149;
            10: v = 32'd1048575;
            11: v = 32'd524287;
            12: v = 32'd262143;
            13: v = 32'd131071;
            14: v = 32'd65535;
            15: v = 32'd32767;
            16: v = 32'd16383;
            17: v = 32'd8191;
            18: v = 32'd4095;
            19: v = 32'd2047;
            20: v = 32'd1023;
            21: v = 32'd511;
            22: v = 32'd255;
            23: v = 32'd127;
            24: v = 32'd63;
            25: v = 32'd31;
            26: v = 32'd15;
            27: v = 32'd8;
            28: v = 32'd4;
            29: v = 32'd2;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/ghd_rad.sv
module ghd_rad (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          vld_in,
    input  logic signed [ghd_pkg::DW-1:0] deg,
    output logic                          vld_out,
    output logic signed [ghd_pkg::AW-1:0] ang,
    output logic                          neg
);
    import ghd_pkg::*;

    localparam logic signed [18:0] KHS = 19'(K_HI);
    localparam logic signed [18:0] KLS = 19'(K_LO);

    logic [3:0] vld_reg;
    logic signed [44:0] phi_reg;
    logic signed [44:0] plo_reg;
    logic signed [AW-1:0] a_reg;
    logic signed [AW-1:0] r_reg;
    logic signed [AW-1:0] f_reg;
    logic neg_reg;
    logic signed [63:0] sum;
    logic signed [AW-1:0] a_next;
    logic signed [AW-1:0] r_next;
    logic signed [AW-1:0] f_next;
    logic neg_next;

    always_comb
    begin
        sum = (64'(phi_reg) <<< 18) + 64'(plo_reg) + 64'sd67108864;
        a_next = AW'(sum >>> 27);
        if (a_reg > PI_Q30)
        begin
            r_next = a_reg - TWO_PI_Q30;
        end
        else if (a_reg < -PI_Q30)
        begin
            r_next = a_reg + TWO_PI_Q30;
        end
        else
        begin
            r_next = a_reg;
        end
        // Fold into the right half plane; sine and cosine flip sign.
        if (r_reg > HALF_PI_Q30)
        begin
            f_next = r_reg - PI_Q30;
            neg_next = 1'b1;
        end
        else if (r_reg < -HALF_PI_Q30)
        begin
            f_next = r_reg + PI_Q30;
            neg_next = 1'b1;
        end
        else
        begin
            f_next = r_reg;
            neg_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        phi_reg <= 45'(deg * KHS);
        plo_reg <= 45'(deg * KLS);
        a_reg <= a_next;
        r_reg <= r_next;
        f_reg <= f_next;
        neg_reg <= neg_next;
    end

    assign vld_out = vld_reg[3];
    assign ang = f_reg;
    assign neg = neg_reg;

endmodule

### hw/rtl/ghd_rot.sv
module ghd_rot (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          vld_in,
    input  logic signed [ghd_pkg::AW-1:0] ang,
    input  logic                          neg,
    output logic                          vld_out,
    output logic signed [31:0]            sin_q,
    output logic signed [31:0]            cos_q
);
    import ghd_pkg::*;

    logic signed [CW-1:0] x_reg [ITERS+1];
    logic signed [CW-1:0] y_reg [ITERS+1];
    logic signed [AW-1:0] z_reg [ITERS+1];
    logic neg_reg [ITERS+1];
    logic vld_reg [ITERS+1];
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;
    logic out_vld_reg;

    assign x_reg[0] = GAIN_Q30;
    assign y_reg[0] = '0;
    assign z_reg[0] = ang;
    assign neg_reg[0] = neg;
    assign vld_reg[0] = vld_in;

    for (genvar i = 0; i < ITERS; i++)
    begin : g_stage
        localparam logic signed [AW-1:0] ATAN = AW'(atan_val(i));
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            neg_reg[i+1] <= neg_reg[i];
            if (z_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] - dx;
                y_reg[i+1] <= y_reg[i] + dy;
                z_reg[i+1] <= z_reg[i] - ATAN;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + dx;
                y_reg[i+1] <= y_reg[i] - dy;
                z_reg[i+1] <= z_reg[i] + ATAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= vld_reg[ITERS];
        end
    end

    always_ff @(posedge clk)
    begin
        sin_reg <= neg_reg[ITERS] ? -y_reg[ITERS][31:0] : y_reg[ITERS][31:0];
        cos_reg <= neg_reg[ITERS] ? -x_reg[ITERS][31:0] : x_reg[ITERS][31:0];
    end

    assign vld_out = out_vld_reg;
    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

### hw/rtl/ghd_sqrt.sv
module ghd_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        vld_in,
    input  logic [30:0] val,
    output logic        vld_out,
    output logic [30:0] root
);
    localparam int NB = 31;

    logic [61:0] rem_reg [NB+1];
    logic [30:0] root_reg [NB+1];
    logic vld_reg [NB+1];

    // The radicand is the Q30 value shifted up by 30, so the root is Q30.
    assign rem_reg[0] = {1'b0, val, 30'b0};
    assign root_reg[0] = '0;
    assign vld_reg[0] = vld_in;

    for (genvar j = 0; j < NB; j++)
    begin : g_bit
        localparam int K = NB - 1 - j;
        logic [61:0] term;
        assign term = ({31'b0, root_reg[j]} << (K + 1)) | (62'd1 << (2 * K));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rem_reg[j] >= term)
            begin
                rem_reg[j+1] <= rem_reg[j] - term;
                root_reg[j+1] <= root_reg[j] | (31'd1 << K);
            end
            else
            begin
                rem_reg[j+1] <= rem_reg[j];
                root_reg[j+1] <= root_reg[j];
            end
        end
    end

    assign vld_out = vld_reg[NB];
    assign root = root_reg[NB];

endmodule

### hw/rtl/ghd_vec.sv
module ghd_vec (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        vld_in,
    input  logic [30:0] ys,
    input  logic [30:0] xs,
    output logic        vld_out,
    output logic [30:0] ang
);
    import ghd_pkg::*;

    localparam logic signed [CW-1:0] HALF_PI = CW'(HALF_PI_Q30);

    logic signed [CW-1:0] x_reg [ITERS+1];
    logic signed [CW-1:0] y_reg [ITERS+1];
    logic signed [CW-1:0] z_reg [ITERS+1];
    logic vld_reg [ITERS+1];
    logic [30:0] ang_reg;
    logic out_vld_reg;
    logic [30:0] ang_next;

    assign x_reg[0] = CW'({1'b0, xs});
    assign y_reg[0] = CW'({1'b0, ys});
    assign z_reg[0] = '0;
    assign vld_reg[0] = vld_in;

    for (genvar i = 0; i < ITERS; i++)
    begin : g_stage
        localparam logic signed [CW-1:0] ATAN = CW'(atan_val(i));
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (y_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] + dx;
                y_reg[i+1] <= y_reg[i] - dy;
                z_reg[i+1] <= z_reg[i] + ATAN;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - dx;
                y_reg[i+1] <= y_reg[i] + dy;
                z_reg[i+1] <= z_reg[i] - ATAN;
            end
        end
    end

    always_comb
    begin
        if (z_reg[ITERS] < 0)
        begin
            ang_next = '0;
        end
        else if (z_reg[ITERS] > HALF_PI)
        begin
            ang_next = HALF_PI[30:0];
        end
        else
        begin
            ang_next = z_reg[ITERS][30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= vld_reg[ITERS];
        end
    end

    always_ff @(posedge clk)
    begin
        ang_reg <= ang_next;
    end

    assign vld_out = out_vld_reg;
    assign ang = ang_reg;

endmodule

### hw/rtl/great_circle_distance_haversine.sv
// Start to done: radians, rotation CORDIC, products, square roots, vectoring CORDIC, scaling.
// Throughput: one coordinate pair per cycle; busy is never raised.
// The depth is set by the two CORDIC pipelines and the 31-stage square root.
// The receiver cannot stall: each result shows for one cycle with done high.
// Reset clears all valid bits and sets the radius to 3956.
module great_circle_distance_haversine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [23:0] lat_a,
    input  logic signed [24:0] lon_a,
    input  logic signed [23:0] lat_b,
    input  logic signed [24:0] lon_b,
    output logic               done,
    output logic [22:0]        arc_length,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [12:0]        cfg_data
);
    import ghd_pkg::*;

    function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return 32'(p >>> 30);
    endfunction

    logic [12:0] radius_reg;
    logic signed [DW-1:0] d_lat;
    logic signed [DW-1:0] d_lon;
    logic signed [DW-1:0] d_la;
    logic signed [DW-1:0] d_lb;
    logic rad_vld;
    logic signed [AW-1:0] ang_dlat, ang_dlon, ang_la, ang_lb;
    logic neg_dlat, neg_dlon, neg_la, neg_lb;
    logic rot_vld;
    logic signed [31:0] s_lat, s_lon, c_a, c_b;
    logic [3:0] mid_vld_reg;
    logic signed [31:0] s2lat_reg, s2lon_reg, cab_reg;
    logic signed [31:0] s2lat2_reg, m_reg;
    logic [30:0] t_reg;
    logic [30:0] ys_in_reg, xs_in_reg;
    logic signed [32:0] t_sum;
    logic [30:0] t_next;
    logic sq_vld;
    logic [30:0] ys, xs;
    logic vec_vld;
    logic [30:0] cang;
    logic [1:0] fin_vld_reg;
    logic [44:0] prod_reg;
    logic [22:0] arc_reg;
    logic [45:0] rnd;
    logic [23:0] arc_full;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_valid)
        begin
            radius_reg <= cfg_data;
        end
    end

    // Point latitudes are doubled so all four angles share the half-angle scale.
    assign d_lat = DW'(lat_b) - DW'(lat_a);
    assign d_lon = DW'(lon_b) - DW'(lon_a);
    assign d_la = DW'(lat_a) <<< 1;
    assign d_lb = DW'(lat_b) <<< 1;

    ghd_rad u_rad_dlat (.clk, .rst_n, .vld_in(start), .deg(d_lat), .vld_out(rad_vld),
                        .ang(ang_dlat), .neg(neg_dlat));
    ghd_rad u_rad_dlon (.clk, .rst_n, .vld_in(start), .deg(d_lon), .vld_out(),
                        .ang(ang_dlon), .neg(neg_dlon));
    ghd_rad u_rad_la (.clk, .rst_n, .vld_in(start), .deg(d_la), .vld_out(),
                      .ang(ang_la), .neg(neg_la));
    ghd_rad u_rad_lb (.clk, .rst_n, .vld_in(start), .deg(d_lb), .vld_out(),
                      .ang(ang_lb), .neg(neg_lb));

    ghd_rot u_rot_dlat (.clk, .rst_n, .vld_in(rad_vld), .ang(ang_dlat), .neg(neg_dlat),
                        .vld_out(rot_vld), .sin_q(s_lat), .cos_q());
    ghd_rot u_rot_dlon (.clk, .rst_n, .vld_in(rad_vld), .ang(ang_dlon), .neg(neg_dlon),
                        .vld_out(), .sin_q(s_lon), .cos_q());
    ghd_rot u_rot_la (.clk, .rst_n, .vld_in(rad_vld), .ang(ang_la), .neg(neg_la),
                      .vld_out(), .sin_q(), .cos_q(c_a));
    ghd_rot u_rot_lb (.clk, .rst_n, .vld_in(rad_vld), .ang(ang_lb), .neg(neg_lb),
                      .vld_out(), .sin_q(), .cos_q(c_b));

    always_comb
    begin
        t_sum = 33'(s2lat2_reg) + 33'(m_reg);
        if (t_sum < 0)
        begin
            t_next = '0;
        end
        else if (t_sum > 33'(ONE_Q30))
        begin
            t_next = ONE_Q30;
        end
        else
        begin
            t_next = t_sum[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_vld_reg <= '0;
            fin_vld_reg <= '0;
        end
        else
        begin
            mid_vld_reg <= {mid_vld_reg[2:0], rot_vld};
            fin_vld_reg <= {fin_vld_reg[0], vec_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        s2lat_reg <= mul_q30(s_lat, s_lat);
        s2lon_reg <= mul_q30(s_lon, s_lon);
        cab_reg <= mul_q30(c_a, c_b);
        s2lat2_reg <= s2lat_reg;
        m_reg <= mul_q30(cab_reg, s2lon_reg);
        t_reg <= t_next;
        ys_in_reg <= t_reg;
        xs_in_reg <= ONE_Q30 - t_reg;
    end

    ghd_sqrt u_sqrt_y (.clk, .rst_n, .vld_in(mid_vld_reg[3]), .val(ys_in_reg),
                       .vld_out(sq_vld), .root(ys));
    ghd_sqrt u_sqrt_x (.clk, .rst_n, .vld_in(mid_vld_reg[3]), .val(xs_in_reg),
                       .vld_out(), .root(xs));

    ghd_vec u_vec (.clk, .rst_n, .vld_in(sq_vld), .ys(ys), .xs(xs),
                   .vld_out(vec_vld), .ang(cang));

    always_comb
    begin
        rnd = 46'(prod_reg) + 46'd2097152;
        arc_full = 24'(rnd >> 22);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 45'(radius_reg) * 45'({cang, 1'b0});
        arc_reg <= arc_full[23] ? 23'h7F_FFFF : arc_full[22:0];
    end

    assign done = fin_vld_reg[1];
    assign arc_length = arc_reg;

endmodule

### sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ghd_pkg::*;

    localparam longint LAT_MAX = 5898240;
    localparam longint LON_MAX = 11796480;
    localparam longint K_RAD = 64'sd19190098069;
    localparam longint PI_Q = 64'sd3373259426;
    localparam longint HALF_PI_Q = 64'sd1686629713;
    localparam longint TWO_PI_Q = 64'sd6746518852;
    localparam longint GAIN_Q = 64'sd652032874;
    localparam longint UNIT_Q = 64'sd1073741824;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [23:0] lat_a;
    logic signed [24:0] lon_a;
    logic signed [23:0] lat_b;
    logic signed [24:0] lon_b;
    logic done;
    logic [22:0] arc_length;
    logic cfg_valid;
    logic cfg_ready;
    logic [12:0] cfg_data;

    logic [12:0] radius;
    logic [22:0] pending_arcs[$];
    int mismatches;
    int idle_pct;
    longint arctan_steps[32];

    great_circle_distance_haversine uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .lat_a(lat_a),
        .lon_a(lon_a),
        .lat_b(lat_b),
        .lon_b(lon_b),
        .done(done),
        .arc_length(arc_length),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint scale_to_radians(longint deg, int sh);
        return (deg * K_RAD + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint round_mul(longint a, longint b);
        return (a * b + (UNIT_Q >>> 1)) >>> 30;
    endfunction

    task automatic rotate_angle(input longint ang, output longint sin_v, output longint cos_v);
        longint x, y, z, dx, dy;
        bit flip;
        x = GAIN_Q;
        y = 0;
        flip = 1'b0;
        while (ang > PI_Q) ang -= TWO_PI_Q;
        while (ang < -PI_Q) ang += TWO_PI_Q;
        if (ang > HALF_PI_Q)
        begin
            ang -= PI_Q;
            flip = 1'b1;
        end
        else if (ang < -HALF_PI_Q)
        begin
            ang += PI_Q;
            flip = 1'b1;
        end
        z = ang;
        for (int i = 0; i < ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arctan_steps[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arctan_steps[i];
            end
        end
        sin_v = flip ? -y : y;
        cos_v = flip ? -x : x;
    endtask

    function automatic longint int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += arctan_steps[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= arctan_steps[i];
            end
        end
        if (z < 0) z = 0;
        if (z > HALF_PI_Q) z = HALF_PI_Q;
        return z;
    endfunction

    task automatic predict_arc(input longint la, input longint oa, input longint lb,
                               input longint ob, output logic [22:0] arc);
        longint s, c, hav_lat, hav_lon, cos_a, cos_b, t, ang;
        logic [63:0] arc_wide;
        rotate_angle(scale_to_radians(lb - la, 27), s, c);
        hav_lat = round_mul(s, s);
        rotate_angle(scale_to_radians(ob - oa, 27), s, c);
        hav_lon = round_mul(s, s);
        rotate_angle(scale_to_radians(la, 26), s, cos_a);
        rotate_angle(scale_to_radians(lb, 26), s, cos_b);
        t = hav_lat + round_mul(round_mul(cos_a, cos_b), hav_lon);
        if (t < 0) t = 0;
        if (t > UNIT_Q) t = UNIT_Q;
        ang = vector_angle(int_sqrt(64'(t) << 30), int_sqrt(64'(UNIT_Q - t) << 30));
        arc_wide = (64'(radius) * 2 * 64'(ang) + (64'd1 << 21)) >> 22;
        arc = (arc_wide > 64'h7FFFFF) ? 23'h7FFFFF : arc_wide[22:0];
    endtask

    // Drive one coordinate pair and hold it until the block takes the beat.
    task automatic send_pair(input longint la, input longint oa, input longint lb,
                             input longint ob);
        logic [22:0] arc;
        bit taken;
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        lat_a <= 24'(la);
        lon_a <= 25'(oa);
        lat_b <= 24'(lb);
        lon_b <= 25'(ob);
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
        end
        predict_arc(longint'(lat_a), longint'(lon_a), longint'(lat_b), longint'(lon_b), arc);
        pending_arcs.push_back(arc);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_arcs.size() != 0) @(posedge clk);
    endtask

    task automatic write_radius(input logic [12:0] value);
        bit taken;
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = cfg_ready;
        end
        radius = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic longint rand_lat();
        return longint'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
    endfunction

    function automatic longint rand_lon();
        return longint'($urandom_range(2 * LON_MAX)) - LON_MAX;
    endfunction

    task automatic test_directed();
        idle_pct = 0;
        send_pair(0, 0, 0, 0);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        send_pair(0, -LON_MAX, 0, LON_MAX);
        send_pair(0, 0, 0, LON_MAX);
        send_pair(0, 0, 0, 1);
        send_pair(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX);
        send_pair(2621440, -6291456, 2621440, -6291457);
        send_pair(-1, -1, -1, -1);
        // Full-width values beyond the stated ranges exercise angle reduction.
        send_pair(-(64'sd1 << 23), -(64'sd1 << 24), (64'sd1 << 23) - 1, (64'sd1 << 24) - 1);
        send_pair((64'sd1 << 23) - 1, (64'sd1 << 24) - 1, -(64'sd1 << 23), -(64'sd1 << 24));
        send_pair(0, 0, 0, (64'sd1 << 24) - 1);
        send_pair(2000000, 3000000, -2000000, 3000000 - LON_MAX);
    endtask

    task automatic test_radius_settings();
        logic [12:0] settings[5] = '{13'd8191, 13'd1, 13'd0, 13'd4096, 13'd3956};
        foreach (settings[k])
        begin
            write_radius(settings[k]);
            send_pair(LAT_MAX, 0, -LAT_MAX, 0);
            send_pair(0, -LON_MAX, 0, LON_MAX);
            send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
            send_pair(100, 200, 100, 201);
        end
    endtask

    task automatic test_random(input int count, input int gap_pct);
        idle_pct = gap_pct;
        write_radius(13'($urandom_range(1, 8191)));
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(9))
                0: send_pair(24'($urandom), 25'($urandom), 24'($urandom), 25'($urandom));
                1: send_pair(longint'($signed(24'($urandom))), longint'($signed(25'($urandom))),
                             longint'($signed(24'($urandom))), longint'($signed(25'($urandom))));
                2:
                begin
                    // Nearby points stress the small-angle end.
                    longint la = rand_lat(), oa = rand_lon();
                    send_pair(la, oa, la + $urandom_range(64) - 32, oa + $urandom_range(64) - 32);
                end
                default: send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
            endcase
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_arcs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: arc_length=%0d", arc_length);
            end
            else
            begin
                logic [22:0] want;
                want = pending_arcs.pop_front();
                if (arc_length !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("arc_length mismatch: expected %0d, got %0d", want, arc_length);
                end
            end
        end
    end

    initial
    begin
        arctan_steps = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                         16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                         131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
                         127, 63, 31, 15, 8, 4, 2, 1, 0};
        mismatches = 0;
        idle_pct = 0;
        radius = 13'd3956;
        rst_n = 1'b0;
        start = 1'b0;
        lat_a = '0;
        lon_a = '0;
        lat_b = '0;
        lon_b = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_radius_settings();
        test_random(300, 0);
        test_random(250, 66);
        test_random(200, 16);
        test_random(250, 0);
        write_radius(13'd8191);
        test_random(50, 16);

        wait_drained();
        repeat (120) @(posedge clk);
        if (mismatches == 0 && pending_arcs.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### great_circle_distance_haversine.f
hw/rtl/ghd_pkg.sv
hw/rtl/ghd_rad.sv
hw/rtl/ghd_rot.sv
hw/rtl/ghd_sqrt.sv
hw/rtl/ghd_vec.sv
hw/rtl/great_circle_distance_haversine.sv
sim/testbench.sv
